// ===== hdl/radar_column_topk_to_points_core_macros.svh =====
// assertion macros shared by the core modules
`ifndef RADAR_COLUMN_TOPK_TO_POINTS_CORE_MACROS_SVH
`define RADAR_COLUMN_TOPK_TO_POINTS_CORE_MACROS_SVH

// same-cycle implication
`define RCTP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rctp_pkg.sv =====
// ---------------------------------------------------------------------------
// rctp_pkg
// shared constants, types and the sin/cos table builder of the top-k core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rctp_pkg;

    localparam int TopK     = 20;
    localparam int Azimuths = 400;

    localparam int IntW    = 8;
    localparam int RowW    = 10;
    localparam int ColW    = 9;
    localparam int RowEndW = 11;
    localparam int StepW   = 16;
    localparam int PosW    = 32;
    localparam int PtrW    = (TopK > 1) ? $clog2(TopK) : 1;
    localparam int AddrW   = $clog2(Azimuths);
    localparam int AngW    = $clog2(2 * Azimuths) + 2;
    localparam int TrigUW  = 17;
    localparam int TrigW   = TrigUW + 1;
    localparam int RangeW  = StepW + RowW + 3;
    localparam int ProdW   = RangeW + TrigW;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_ROW_START  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ROW_END    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_RANGE_STEP = 2'd2;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [63:0] HalfPiQ60 = 64'h1921FB54442D1846;
    localparam logic [63:0] OneQ60    = 64'h1000000000000000;

    typedef struct packed {
        logic load_pixel;
        logic scan_init;
        logic scan_step;
        logic slot_write;
        logic emit_init;
        logic emit_addr;
        logic emit_sel;
        logic emit_mul;
        logic emit_out;
        logic emit_next;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic in_window;
        logic last;
        logic ptr_last;
        logic out_free;
    } t_dp_sts;

    typedef logic [2*TrigUW-1:0] t_rom_table [Azimuths];

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic t_rom_table build_rom();
        t_rom_table t;
        logic [63:0] rr;
        logic [63:0] phi;
        logic [63:0] phi2;
        logic [63:0] st;
        logic [63:0] ct;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] s16;
        logic [63:0] c16;
        for (int r = 0; r < Azimuths; r++) begin
            rr   = 64'(r);
            phi  = rr * (HalfPiQ60 / Azimuths) + (rr * (HalfPiQ60 % Azimuths)) / Azimuths;
            phi2 = mul_q60(phi, phi);
            st   = phi;
            ct   = OneQ60;
            s    = phi;
            c    = OneQ60;
            for (int k = 1; k <= 14; k++) begin
                st = mul_q60(st, phi2) / 64'((2 * k) * (2 * k + 1));
                ct = mul_q60(ct, phi2) / 64'((2 * k - 1) * (2 * k));
                if ((k % 2) == 1) begin
                    s = s - st;
                    c = c - ct;
                end else begin
                    s = s + st;
                    c = c + ct;
                end
            end
            s16  = (s + (64'd1 << 43)) >> 44;
            c16  = (c + (64'd1 << 43)) >> 44;
            t[r] = {s16[TrigUW-1:0], c16[TrigUW-1:0]};
        end
        return t;
    endfunction

endpackage

// ===== hdl/rctp_trig_rom.sv =====
// ---------------------------------------------------------------------------
// rctp_trig_rom
// first-quadrant sin/cos table, q1.16 magnitudes, registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rctp_trig_rom (
    input  logic                                i_clk,
    input  logic [rctp_pkg::AddrW-1:0]          i_addr,
    output logic [rctp_pkg::TrigUW-1:0]         o_sin,
    output logic [rctp_pkg::TrigUW-1:0]         o_cos
);

    localparam rctp_pkg::t_rom_table RomTable = rctp_pkg::build_rom();

    logic [2*rctp_pkg::TrigUW-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= RomTable[i_addr];
    end

    assign o_sin = r_data[2*rctp_pkg::TrigUW-1:rctp_pkg::TrigUW];
    assign o_cos = r_data[rctp_pkg::TrigUW-1:0];

endmodule

// ===== hdl/rctp_ctrl.sv =====
// ---------------------------------------------------------------------------
// rctp_ctrl
// sequencer: pixel intake, min-slot scan, slot update and point emission
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radar_column_topk_to_points_core_macros.svh"

module rctp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rctp_pkg::t_dp_sts i_sts,
    output rctp_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WRITE,
        S_EMIT_A,
        S_EMIT_R,
        S_EMIT_S,
        S_EMIT_M
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;
    logic   r_emit_out_st, n_emit_out_st;

    always_comb begin
        n_state       = r_state;
        n_emit_out_st = r_emit_out_st;
        o_cmd         = '0;
        if (r_emit_out_st) begin
            if (i_sts.out_free) begin
                o_cmd.emit_out = 1'b1;
                n_emit_out_st  = 1'b0;
                if (i_sts.ptr_last) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.emit_next = 1'b1;
                    n_state         = S_EMIT_A;
                end
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !r_in_stall) begin
                        o_cmd.load_pixel = 1'b1;
                        n_state          = S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_sts.in_window) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = (rctp_pkg::TopK > 1) ? S_SCAN : S_WRITE;
                    end else if (i_sts.last) begin
                        o_cmd.emit_init = 1'b1;
                        n_state         = S_EMIT_A;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
                S_SCAN: begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.ptr_last) begin
                        n_state = S_WRITE;
                    end
                end
                S_WRITE: begin
                    o_cmd.slot_write = 1'b1;
                    if (i_sts.last) begin
                        o_cmd.emit_init = 1'b1;
                        n_state         = S_EMIT_A;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
                S_EMIT_A: begin
                    o_cmd.emit_addr = 1'b1;
                    n_state         = S_EMIT_R;
                end
                S_EMIT_R: begin
                    n_state = S_EMIT_S;
                end
                S_EMIT_S: begin
                    o_cmd.emit_sel = 1'b1;
                    n_state        = S_EMIT_M;
                end
                S_EMIT_M: begin
                    o_cmd.emit_mul = 1'b1;
                    n_emit_out_st  = 1'b1;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_in_stall    <= 1'b0;
            r_emit_out_st <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_in_stall    <= (n_state != S_IDLE) || n_emit_out_st;
            r_emit_out_st <= n_emit_out_st;
        end
    end

    assign o_in_stall = r_in_stall;

    `RCTP_ASSERT_NEXT(a_accept_to_check, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        r_state == S_CHECK && o_in_stall, "accepted word did not start processing")
    `RCTP_ASSERT_NEXT(a_write_no_last_idle, i_clk, i_rst_n,
        r_state == S_WRITE && !i_sts.last, r_state == S_IDLE && !o_in_stall,
        "slot update without column end did not return to idle")

endmodule

// ===== hdl/rctp_dp.sv =====
// ---------------------------------------------------------------------------
// rctp_dp
// slot store, min-slot scan, range and trig products, output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radar_column_topk_to_points_core_macros.svh"

module rctp_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rctp_pkg::t_dp_cmd                    i_cmd,
    output rctp_pkg::t_dp_sts                    o_sts,
    input  logic                                 i_cfg_we,
    input  logic [rctp_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [31:0]                          i_cfg_data,
    input  logic [rctp_pkg::IntW-1:0]            i_intensity,
    input  logic [rctp_pkg::RowW-1:0]            i_row,
    input  logic [rctp_pkg::ColW-1:0]            i_column,
    input  logic                                 i_last_in_column,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic signed [rctp_pkg::PosW-1:0]     o_x_pos,
    output logic signed [rctp_pkg::PosW-1:0]     o_y_pos,
    output logic [rctp_pkg::IntW-1:0]            o_point_intensity,
    output logic                                 o_last_point
);

    localparam int K   = rctp_pkg::TopK;
    localparam int PW  = rctp_pkg::PtrW;
    localparam int AW  = rctp_pkg::AngW;
    localparam int RW  = rctp_pkg::ProdW + 2;

    logic [rctp_pkg::RowW-1:0]    r_row_start;
    logic [rctp_pkg::RowEndW-1:0] r_row_end;
    logic [rctp_pkg::StepW-1:0]   r_range_step;

    logic [rctp_pkg::IntW-1:0] r_px_int;
    logic [rctp_pkg::RowW-1:0] r_px_row;
    logic [rctp_pkg::ColW-1:0] r_px_col;
    logic                      r_px_last;

    logic [rctp_pkg::IntW-1:0] r_slot_int [K];
    logic [rctp_pkg::RowW-1:0] r_slot_row [K];
    logic [rctp_pkg::ColW-1:0] r_slot_col [K];
    logic [K-1:0]              r_slot_used;

    logic [PW-1:0]             r_ptr;
    logic [PW-1:0]             r_best_idx;
    logic [rctp_pkg::IntW-1:0] r_best_val;

    logic [1:0]                         r_quad;
    logic [rctp_pkg::AddrW-1:0]         r_rom_addr;
    logic signed [rctp_pkg::RangeW-1:0] r_range;
    logic [rctp_pkg::IntW-1:0]          r_e_int;
    logic                               r_e_last;
    logic signed [rctp_pkg::TrigW-1:0]  r_cs;
    logic signed [rctp_pkg::TrigW-1:0]  r_nsn;
    logic signed [rctp_pkg::ProdW-1:0]  r_px;
    logic signed [rctp_pkg::ProdW-1:0]  r_py;

    logic                               r_out_valid;
    logic signed [rctp_pkg::PosW-1:0]   r_x_pos;
    logic signed [rctp_pkg::PosW-1:0]   r_y_pos;
    logic [rctp_pkg::IntW-1:0]          r_out_int;
    logic                               r_out_last;

    logic [rctp_pkg::IntW-1:0] ptr_int;
    logic [rctp_pkg::IntW-1:0] best0_int;
    logic [rctp_pkg::RowW-1:0] ptr_row;
    logic [rctp_pkg::ColW-1:0] ptr_col;
    logic [AW-1:0]             ang_n1;
    logic [AW-1:0]             ang_n;
    logic [AW-1:0]             ang_m;
    logic [1:0]                ang_q;
    logic [AW-1:0]             ang_r;
    logic signed [rctp_pkg::RowW+2:0]  row_term;
    logic signed [rctp_pkg::TrigW-1:0] rom_s;
    logic signed [rctp_pkg::TrigW-1:0] rom_c;
    logic [rctp_pkg::TrigUW-1:0]       rom_sin;
    logic [rctp_pkg::TrigUW-1:0]       rom_cos;
    logic signed [RW-1:0]              sum_x;
    logic signed [RW-1:0]              sum_y;
    logic                              out_free;

    assign ptr_int   = r_slot_used[r_ptr] ? r_slot_int[r_ptr] : '0;
    assign ptr_row   = r_slot_used[r_ptr] ? r_slot_row[r_ptr] : '0;
    assign ptr_col   = r_slot_used[r_ptr] ? r_slot_col[r_ptr] : '0;
    assign best0_int = r_slot_used[0] ? r_slot_int[0] : '0;

    // angle index (2c+1) mod 2A, then quadrant and offset
    assign ang_n1 = AW'({ptr_col, 1'b1});
    assign ang_n  = (ang_n1 >= AW'(2 * rctp_pkg::Azimuths)) ?
                    ang_n1 - AW'(2 * rctp_pkg::Azimuths) : ang_n1;
    assign ang_m  = {ang_n[AW-2:0], 1'b0};

    always_comb begin
        if (ang_m < AW'(rctp_pkg::Azimuths)) begin
            ang_q = rctp_pkg::QUAD_0;
            ang_r = ang_m;
        end else if (ang_m < AW'(2 * rctp_pkg::Azimuths)) begin
            ang_q = rctp_pkg::QUAD_1;
            ang_r = ang_m - AW'(rctp_pkg::Azimuths);
        end else if (ang_m < AW'(3 * rctp_pkg::Azimuths)) begin
            ang_q = rctp_pkg::QUAD_2;
            ang_r = ang_m - AW'(2 * rctp_pkg::Azimuths);
        end else begin
            ang_q = rctp_pkg::QUAD_3;
            ang_r = ang_m - AW'(3 * rctp_pkg::Azimuths);
        end
    end

    assign row_term = $signed({2'b00, ptr_row, 1'b0}) - 13'sd7;

    rctp_trig_rom u_trig_rom (
        .i_clk  (i_clk),
        .i_addr (r_rom_addr),
        .o_sin  (rom_sin),
        .o_cos  (rom_cos)
    );

    assign rom_s = $signed({1'b0, rom_sin});
    assign rom_c = $signed({1'b0, rom_cos});

    assign sum_x = RW'(r_px) + RW'(65536);
    assign sum_y = RW'(r_py) + RW'(65536);

    assign out_free = !r_out_valid || !i_out_stall;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_start  <= rctp_pkg::RowW'(21);
            r_row_end    <= rctp_pkg::RowEndW'(571);
            r_range_step <= rctp_pkg::StepW'(11469);
            r_slot_used  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rctp_pkg::CFG_ROW_START:  r_row_start  <= i_cfg_data[rctp_pkg::RowW-1:0];
                    rctp_pkg::CFG_ROW_END:    r_row_end    <= i_cfg_data[rctp_pkg::RowEndW-1:0];
                    rctp_pkg::CFG_RANGE_STEP: r_range_step <= i_cfg_data[rctp_pkg::StepW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_slot_used <= '0;
            end else if (i_cmd.slot_write && (r_px_int > r_best_val)) begin
                r_slot_used[r_best_idx] <= 1'b1;
            end
            if (i_cmd.emit_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pixel) begin
            r_px_int  <= i_intensity;
            r_px_row  <= i_row;
            r_px_col  <= i_column;
            r_px_last <= i_last_in_column;
        end
        if (i_cmd.scan_init) begin
            r_best_idx <= '0;
            r_best_val <= best0_int;
            r_ptr      <= PW'(1);
        end else if (i_cmd.scan_step) begin
            if (ptr_int < r_best_val) begin
                r_best_idx <= r_ptr;
                r_best_val <= ptr_int;
            end
            r_ptr <= r_ptr + PW'(1);
        end else if (i_cmd.emit_init) begin
            r_ptr <= '0;
        end else if (i_cmd.emit_next) begin
            r_ptr <= r_ptr + PW'(1);
        end
        if (i_cmd.slot_write && (r_px_int > r_best_val)) begin
            r_slot_int[r_best_idx] <= r_px_int;
            r_slot_row[r_best_idx] <= r_px_row;
            r_slot_col[r_best_idx] <= r_px_col;
        end
        if (i_cmd.emit_addr) begin
            r_quad     <= ang_q;
            r_rom_addr <= ang_r[rctp_pkg::AddrW-1:0];
            r_range    <= rctp_pkg::RangeW'($signed({1'b0, r_range_step}) * row_term);
            r_e_int    <= ptr_int;
            r_e_last   <= (r_ptr == PW'(K - 1));
        end
        if (i_cmd.emit_sel) begin
            case (r_quad)
                rctp_pkg::QUAD_0: begin
                    r_cs  <= rom_c;
                    r_nsn <= -rom_s;
                end
                rctp_pkg::QUAD_1: begin
                    r_cs  <= -rom_s;
                    r_nsn <= -rom_c;
                end
                rctp_pkg::QUAD_2: begin
                    r_cs  <= -rom_c;
                    r_nsn <= rom_s;
                end
                default: begin
                    r_cs  <= rom_s;
                    r_nsn <= rom_c;
                end
            endcase
        end
        if (i_cmd.emit_mul) begin
            r_px <= r_range * r_cs;
            r_py <= r_range * r_nsn;
        end
        if (i_cmd.emit_out) begin
            r_x_pos    <= sum_x[RW-1:17];
            r_y_pos    <= sum_y[RW-1:17];
            r_out_int  <= r_e_int;
            r_out_last <= r_e_last;
        end
    end

    assign o_sts.in_window = ({1'b0, r_px_row} >= {1'b0, r_row_start}) &&
                             ({1'b0, r_px_row} < r_row_end);
    assign o_sts.last      = r_px_last;
    assign o_sts.ptr_last  = (r_ptr == PW'(K - 1));
    assign o_sts.out_free  = out_free;

    assign o_out_valid       = r_out_valid;
    assign o_x_pos           = r_x_pos;
    assign o_y_pos           = r_y_pos;
    assign o_point_intensity = r_out_int;
    assign o_last_point      = r_out_last;

    `RCTP_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_cmd.clear, r_slot_used == '0,
        "slot store not empty after column emission")
    `RCTP_ASSERT_NOW(a_out_load_free, i_clk, i_rst_n, i_cmd.emit_out, out_free,
        "output word overwritten while held")

endmodule

// ===== hdl/radar_column_topk_to_points_core.sv =====
// ---------------------------------------------------------------------------
// radar_column_topk_to_points_core
// keeps the strongest pixels of each azimuth column and emits them as
// cartesian points at the column end
// ---------------------------------------------------------------------------
//   channel   direction   handshake                 payload
//   in        input       i_in_valid / o_in_stall   intensity, row, column, last_in_column
//   out       output      o_out_valid / i_out_stall x_pos, y_pos, point_intensity, last_point
//   cfg       input       i_cfg_valid / o_cfg_ready index, data
//
// one word at a time: a pixel outside the window is only checked, a pixel
// inside it also runs the slot-by-slot minimum scan and the slot update
// column end emits each point through slot read, rom read, quadrant select,
// multiply and round, and is held by any output stall
// synchronous active-low reset restores register defaults and empties slots
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module radar_column_topk_to_points_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [rctp_pkg::IntW-1:0]            i_intensity,
    input  logic [rctp_pkg::RowW-1:0]            i_row,
    input  logic [rctp_pkg::ColW-1:0]            i_column,
    input  logic                                 i_last_in_column,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [rctp_pkg::PosW-1:0]     o_x_pos,
    output logic signed [rctp_pkg::PosW-1:0]     o_y_pos,
    output logic [rctp_pkg::IntW-1:0]            o_point_intensity,
    output logic                                 o_last_point,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rctp_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);

    rctp_pkg::t_dp_cmd cmd;
    rctp_pkg::t_dp_sts sts;
    logic              cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    rctp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rctp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_intensity       (i_intensity),
        .i_row             (i_row),
        .i_column          (i_column),
        .i_last_in_column  (i_last_in_column),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_x_pos           (o_x_pos),
        .o_y_pos           (o_y_pos),
        .o_point_intensity (o_point_intensity),
        .o_last_point      (o_last_point)
    );

endmodule

// ===== tb/sv/radar_column_topk_to_points_core_test.sv =====
// ---------------------------------------------------------------------------
// radar_column_topk_to_points_core_test
// streams polar pixels through the top-k core under several register
// settings, predicts every emitted point and compares it field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [7:0]         inten;
    logic               last;
} t_point;

class point_scoreboard;
    logic [7:0]  slot_int [rctp_pkg::TopK];
    logic [9:0]  slot_row [rctp_pkg::TopK];
    logic [8:0]  slot_col [rctp_pkg::TopK];
    logic        slot_used [rctp_pkg::TopK];
    logic [9:0]  row_lo;
    logic [10:0] row_hi;
    logic [15:0] step;
    t_point      expected_points [$];
    int          errors;
    int          points_seen;

    function new();
        row_lo = 10'd21;
        row_hi = 11'd571;
        step   = 16'd11469;
        errors = 0;
        points_seen = 0;
        clear_slots();
    endfunction

    function void clear_slots();
        for (int k = 0; k < rctp_pkg::TopK; k++) begin
            slot_int[k] = 0;
            slot_row[k] = 0;
            slot_col[k] = 0;
            slot_used[k] = 0;
        end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            rctp_pkg::CFG_ROW_START:  row_lo = val[9:0];
            rctp_pkg::CFG_ROW_END:    row_hi = val[10:0];
            rctp_pkg::CFG_RANGE_STEP: step = val[15:0];
            default: ;
        endcase
    endfunction

    function logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function void sin_cos(input logic [8:0] col, output int sn, output int cs);
        logic [63:0] n;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] phi;
        logic [63:0] phi2;
        logic [63:0] st;
        logic [63:0] ct;
        logic [63:0] s;
        logic [63:0] c;
        int          s16;
        int          c16;
        n = (2 * 64'(col) + 1) % (2 * rctp_pkg::Azimuths);
        q = (2 * n) / rctp_pkg::Azimuths;
        r = 2 * n - q * rctp_pkg::Azimuths;
        phi = r * (64'h1921FB54442D1846 / rctp_pkg::Azimuths)
            + (r * (64'h1921FB54442D1846 % rctp_pkg::Azimuths)) / rctp_pkg::Azimuths;
        phi2 = q60_mul(phi, phi);
        st = phi;
        ct = 64'h1000000000000000;
        s = phi;
        c = ct;
        for (int k = 1; k <= 14; k++) begin
            st = q60_mul(st, phi2) / 64'((2 * k) * (2 * k + 1));
            ct = q60_mul(ct, phi2) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                s = s - st;
                c = c - ct;
            end else begin
                s = s + st;
                c = c + ct;
            end
        end
        s16 = int'((s + (64'd1 << 43)) >> 44);
        c16 = int'((c + (64'd1 << 43)) >> 44);
        case (q[1:0])
            rctp_pkg::QUAD_0: begin sn = s16;  cs = c16;  end
            rctp_pkg::QUAD_1: begin sn = c16;  cs = -s16; end
            rctp_pkg::QUAD_2: begin sn = -s16; cs = -c16; end
            default:          begin sn = -c16; cs = s16;  end
        endcase
    endfunction

    function void note_pixel(logic [7:0] inten, logic [9:0] row, logic [8:0] col,
                             logic last);
        int     best;
        int     sn;
        int     cs;
        longint r2;
        t_point p;
        if (row >= row_lo && 11'(row) < row_hi) begin
            best = 0;
            for (int k = 1; k < rctp_pkg::TopK; k++)
                if (slot_int[k] < slot_int[best]) best = k;
            if (inten > slot_int[best]) begin
                slot_int[best] = inten;
                slot_row[best] = row;
                slot_col[best] = col;
                slot_used[best] = 1;
            end
        end
        if (!last) return;
        for (int k = 0; k < rctp_pkg::TopK; k++) begin
            sin_cos(slot_used[k] ? slot_col[k] : 9'd0, sn, cs);
            r2 = longint'(step) * (2 * longint'(slot_used[k] ? slot_row[k] : 10'd0) - 7);
            p.x = 32'((r2 * cs + 65536) >>> 17);
            p.y = 32'((-(r2 * sn) + 65536) >>> 17);
            p.inten = slot_used[k] ? slot_int[k] : 8'd0;
            p.last = (k == rctp_pkg::TopK - 1);
            expected_points = {expected_points, p};
        end
        clear_slots();
    endfunction

    function void check_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic [7:0] inten, logic last);
        t_point e;
        points_seen++;
        if (expected_points.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected point x=%0d y=%0d i=%0d", x, y, inten);
            return;
        end
        e = expected_points.pop_front();
        if (x !== e.x || y !== e.y || inten !== e.inten || last !== e.last) begin
            errors++;
            if (errors <= 10)
                $display("point mismatch: exp x=%0d y=%0d i=%0d l=%0b got x=%0d y=%0d i=%0d l=%0b",
                         e.x, e.y, e.inten, e.last, x, y, inten, last);
        end
    endfunction
endclass

module radar_column_topk_to_points_core_test;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [7:0]  i_intensity = 0;
    logic [9:0]  i_row = 0;
    logic [8:0]  i_column = 0;
    logic        i_last_in_column = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic signed [31:0] o_x_pos;
    logic signed [31:0] o_y_pos;
    logic [7:0]  o_point_intensity;
    logic        o_last_point;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;

    point_scoreboard points = new();
    bit          gaps_on;
    bit          stalls_on;
    int          stall_left;
    int          pixels_sent;
    int          columns_sent;

    radar_column_topk_to_points_core i_dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            points.check_point(o_x_pos, o_y_pos, o_point_intensity, o_last_point);
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= 0;
            if (o_out_valid && stalls_on) stall_left = $urandom_range(0, 10);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        points.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [7:0] inten, logic [9:0] row, logic [8:0] col,
                              logic last);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_intensity <= inten;
        i_row <= row;
        i_column <= col;
        i_last_in_column <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        points.note_pixel(inten, row, col, last);
        pixels_sent++;
        if (last) columns_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (points.expected_points.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_columns(int count);
        int       n;
        int       len;
        logic [9:0] row;
        logic [8:0] col;
        n = 0;
        while (n < count) begin
            len = $urandom_range(1, 30);
            col = $urandom_range(0, 511);
            gaps_on = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 4) != 0 && points.row_lo < points.row_hi)
                    row = $urandom_range(points.row_lo,
                                         (points.row_hi > 1024) ? 1023 : points.row_hi - 1);
                else
                    row = $urandom_range(0, 1023);
                if ($urandom_range(0, 9) == 0) col = $urandom_range(0, 511);
                send_pixel($urandom_range(0, 255), row, col, j == len - 1);
                n++;
                if (n == count / 2 && j != len - 1) begin
                    i_in_valid <= 0;
                    while (points.expected_points.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        pixels_sent = 0;
        columns_sent = 0;
        stall_left = 0;
        gaps_on = 0;
        stalls_on = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // default registers: extremes, ties, overflow of the store, wrap
        send_pixel(8'd255, 10'd21, 9'd0, 0);
        send_pixel(8'd0, 10'd570, 9'd0, 0);
        send_pixel(8'd1, 10'd20, 9'd0, 0);
        send_pixel(8'd9, 10'd571, 9'd0, 0);
        send_pixel(8'd100, 10'd1023, 9'd399, 1);
        for (int j = 0; j < 22; j++)
            send_pixel(8'(j == 21 ? 200 : 50 + j % 3), 10'(100 + j), 9'(j < 11 ? 511 : 256),
                       j == 21);
        send_pixel(8'd7, 10'd0, 9'd400, 1);
        drain();

        gaps_on = 1;
        stalls_on = 1;
        random_columns(40);
        drain();
        write_reg(rctp_pkg::CFG_ROW_START, 32'd0);
        write_reg(rctp_pkg::CFG_ROW_END, 32'd1024);
        write_reg(rctp_pkg::CFG_RANGE_STEP, 32'd65535);
        send_pixel(8'd255, 10'd1023, 9'd300, 0);
        send_pixel(8'd254, 10'd0, 9'd100, 1);
        random_columns(40);
        drain();
        write_reg(rctp_pkg::CFG_ROW_START, 32'd1023);
        write_reg(rctp_pkg::CFG_RANGE_STEP, 32'd1);
        random_columns(30);
        drain();
        write_reg(rctp_pkg::CFG_ROW_START, 32'd500);
        write_reg(rctp_pkg::CFG_ROW_END, 32'd100);
        write_reg(rctp_pkg::CFG_RANGE_STEP, 32'd300);
        random_columns(30);
        drain();
        write_reg(rctp_pkg::CFG_ROW_START, 32'd0);
        write_reg(rctp_pkg::CFG_ROW_END, 32'd0);
        random_columns(10);
        drain();
        write_reg(rctp_pkg::CFG_ROW_END, 32'd700);
        write_reg(rctp_pkg::CFG_RANGE_STEP, 32'd0);
        random_columns(20);
        drain();
        write_reg(rctp_pkg::CFG_ROW_START, 32'd5);
        write_reg(rctp_pkg::CFG_RANGE_STEP, 32'd40000);
        random_columns(40);
        drain();

        if (points.expected_points.size() != 0) points.errors++;
        $display("covered %0d pixels in %0d columns, %0d points checked", pixels_sent,
                 columns_sent, points.points_seen);
        $display("register settings swept: full, single-row, empty and zero-step windows");
        if (points.errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", points.errors);
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end
endmodule
